### rtl/btpc_pkg.sv
package btpc_pkg;

  localparam int DIV_BITS = 64;

  localparam logic [31:0] TEMP_REF_OFFSET  = 32'd128000;
  localparam logic [63:0] PRESS_FULL_SCALE = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE      = 64'd3125;
  localparam logic [63:0] P1_BIAS          = 64'h0000_8000_0000_0000;
  localparam int          P4_SHIFT         = 35;
  localparam int          P5_SHIFT         = 17;

  typedef enum logic [1:0] {
    REG_TEMP_CAL = 2'd0,
    REG_PRESS_LO = 2'd1,
    REG_PRESS_HI = 2'd2,
    REG_PRESS_P9 = 2'd3
  } cfg_reg_t;

  // Calibration words; t1 and p1 are unsigned, the rest signed.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  // Fields that ride alongside the divider.
  typedef struct packed {
    logic        v;
    logic        qneg;
    logic        invalid;
    logic [31:0] tcenti;
    logic [31:0] tfine;
  } side_t;

  // Partial remainder, dividend shifting into quotient, divisor magnitude.
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] den;
  } div_t;

  typedef struct packed {
    logic        v;
    logic        invalid;
    logic [31:0] press;
    logic [31:0] tfine;
    logic [31:0] tcenti;
  } res_t;

endpackage

### rtl/baro_temp_press_compensation.sv
// Pipeline: 10 prep stages, 64 divider cells, 5 post stages, output register.
// Throughput: one item per cycle while the skid slot is empty; the 64-cell
// divider chain and the pipelined multipliers each take a new item every
// cycle unless the pipeline holds for an occupied skid slot.
// Reset (rst_n low, synchronous): pipeline empty, calibration registers 0.
module baro_temp_press_compensation import btpc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [19:0] raw_temperature, [39:20] raw_pressure
  input  logic [39:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] temperature_centi, [63:32] fine_temperature,
  // [95:64] pressure_q24_8, [96] pressure_invalid
  output logic [103:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [47:0] tcal_r;
  logic [63:0] plo_r, phi_r;
  logic [15:0] p9_r;
  cal_t        cal;
  logic        adv;

  div_t  dchain [DIV_BITS+1];
  side_t schain [DIV_BITS+1];
  res_t  pres;
  res_t  out_r, skid_r;
  logic  out_v_r, skid_v_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r <= '0;
      plo_r  <= '0;
      phi_r  <= '0;
      p9_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TEMP_CAL: tcal_r <= cfg_data[47:0];
        REG_PRESS_LO: plo_r  <= cfg_data;
        REG_PRESS_HI: phi_r  <= cfg_data;
        REG_PRESS_P9: p9_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = tcal_r[15:0];
    cal.t2 = tcal_r[31:16];
    cal.t3 = tcal_r[47:32];
    cal.p1 = plo_r[15:0];
    cal.p2 = plo_r[31:16];
    cal.p3 = plo_r[47:32];
    cal.p4 = plo_r[63:48];
    cal.p5 = phi_r[15:0];
    cal.p6 = phi_r[31:16];
    cal.p7 = phi_r[47:32];
    cal.p8 = phi_r[63:48];
    cal.p9 = p9_r;
  end

  // the whole pipeline holds only while the skid slot is occupied
  assign adv       = ~skid_v_r;
  assign in_tready = adv;

  btpc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_v   (in_tvalid),
    .raw_t  (in_tdata[19:0]),
    .raw_p  (in_tdata[39:20]),
    .cal    (cal),
    .div_o  (dchain[0]),
    .side_o (schain[0])
  );

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
    btpc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .div_i  (dchain[i]),
      .side_i (schain[i]),
      .div_o  (dchain[i+1]),
      .side_o (schain[i+1])
    );
  end

  btpc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .quo    (dchain[DIV_BITS].num),
    .side_i (schain[DIV_BITS]),
    .cal    (cal),
    .res_o  (pres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= pres.v;
      end
    end else if (pres.v) begin
      // output stalled: park the arriving item
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : pres;
    end
    if (adv && out_v_r && !out_tready) begin
      skid_r <= pres;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_r.invalid, out_r.press, out_r.tfine, out_r.tcenti};

endmodule

### rtl/btpc_front.sv
module btpc_front import btpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_v,
  input  logic [19:0] raw_t,
  input  logic [19:0] raw_p,
  input  cal_t        cal,
  output div_t        div_o,
  output side_t       side_o
);

  logic [9:0] v_r;

  // temperature stages
  logic [31:0] a_r, b_r, m1_r, m2_r, tv1_r, x_r, tfine4_r;
  logic [31:0] a_nxt, b_nxt, m1_nxt, m2_nxt, tv1_nxt, x_nxt, xs, xa, tfine_nxt;
  logic [31:0] t5, tcenti_nxt;
  logic [19:0] p_r [1:8];
  logic [31:0] tc_r [5:9];
  logic [31:0] tf_r [5:9];

  // pressure stages
  logic signed [32:0] vd_r, vd_nxt;
  logic signed [65:0] sq_full;
  logic signed [48:0] vp5_full, vp2_full;
  logic [63:0] sq_r, vp5_r, vp2_r, pv2_r, t_r, den8_r, den9_r, num_r;
  logic [63:0] sq_nxt, vp5_nxt, vp2_nxt;
  logic signed [79:0] sq6_full, sq3_full;
  logic [63:0] pv2_nxt, t_nxt, sq3s, bias_sum, den_nxt, pdiff, num_nxt;
  logic [63:0] pv2_8_r;
  logic signed [80:0] u_full;
  logic        inv_r;
  div_t        div_r;
  side_t       side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[8:0], in_v};
    end
  end

  always_comb begin
    // temperature, 32-bit wrapping
    a_nxt = {15'b0, raw_t[19:3]} - {15'b0, cal.t1, 1'b0};
    b_nxt = {16'b0, raw_t[19:4]} - {16'b0, cal.t1};
    m1_nxt = a_r * {{16{cal.t2[15]}}, cal.t2};
    m2_nxt = b_r * b_r;
    tv1_nxt = $signed(m1_r) >>> 11;
    xs = $signed(m2_r) >>> 12;
    x_nxt = xs * {{16{cal.t3[15]}}, cal.t3};
    xa = $signed(x_r) >>> 14;
    tfine_nxt = tv1_r + xa;
    t5 = tfine4_r * 32'd5 + 32'd128;
    tcenti_nxt = $signed(t5) >>> 8;
    vd_nxt = $signed({tfine4_r[31], tfine4_r}) - $signed({1'b0, TEMP_REF_OFFSET});

    // pressure, 64-bit wrapping
    sq_full  = vd_r * vd_r;
    vp5_full = vd_r * $signed(cal.p5);
    vp2_full = vd_r * $signed(cal.p2);
    sq_nxt   = sq_full[63:0];
    vp5_nxt  = {{15{vp5_full[48]}}, vp5_full} << P5_SHIFT;
    vp2_nxt  = {{15{vp2_full[48]}}, vp2_full} << 12;

    sq6_full = $signed(sq_r) * $signed(cal.p6);
    sq3_full = $signed(sq_r) * $signed(cal.p3);
    pv2_nxt  = sq6_full[63:0] + vp5_r + ({{48{cal.p4[15]}}, cal.p4} << P4_SHIFT);
    sq3s     = $signed(sq3_full[63:0]) >>> 8;
    t_nxt    = sq3s + vp2_r;

    bias_sum = P1_BIAS + t_r;
    u_full   = $signed(bias_sum) * $signed({1'b0, cal.p1});
    den_nxt  = $signed(u_full[63:0]) >>> 33;

    pdiff    = PRESS_FULL_SCALE - {44'b0, p_r[8]};
    num_nxt  = ((pdiff << 31) - pv2_8_r) * PRESS_SCALE;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      p_r[1]   <= raw_p;
      m1_r     <= m1_nxt;
      m2_r     <= m2_nxt;
      tv1_r    <= tv1_nxt;
      x_r      <= x_nxt;
      tfine4_r <= tfine_nxt;
      for (int i = 2; i <= 8; i++) p_r[i] <= p_r[i-1];
      tc_r[5]  <= tcenti_nxt;
      tf_r[5]  <= tfine4_r;
      for (int i = 6; i <= 9; i++) begin
        tc_r[i] <= tc_r[i-1];
        tf_r[i] <= tf_r[i-1];
      end
      vd_r     <= vd_nxt;
      sq_r     <= sq_nxt;
      vp5_r    <= vp5_nxt;
      vp2_r    <= vp2_nxt;
      pv2_r    <= pv2_nxt;
      t_r      <= t_nxt;
      pv2_8_r  <= pv2_r;
      den8_r   <= den_nxt;
      den9_r   <= den8_r;
      num_r    <= num_nxt;
      inv_r    <= (den8_r == '0);
      // take magnitudes for the unsigned divider chain
      div_r.rem <= '0;
      div_r.num <= num_r[63] ? (64'd0 - num_r) : num_r;
      div_r.den <= den9_r[63] ? (64'd0 - den9_r) : den9_r;
      side_r.v       <= v_r[8];
      side_r.qneg    <= num_r[63] ^ den9_r[63];
      side_r.invalid <= inv_r;
      side_r.tcenti  <= tc_r[9];
      side_r.tfine   <= tf_r[9];
    end
  end

  always_comb begin
    div_o  = div_r;
    side_o = side_r;
    side_o.v = v_r[9];
  end

endmodule

### rtl/btpc_div_cell.sv
module btpc_div_cell import btpc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  div_t  div_i,
  input  side_t side_i,
  output div_t  div_o,
  output side_t side_o
);

  logic [64:0] trial;
  logic [64:0] diff;
  logic        qbit;
  div_t        div_r, div_nxt;
  side_t       side_r;

  // one restoring step: quotient bit enters at the bottom of num
  always_comb begin
    trial = {div_i.rem, div_i.num[63]};
    diff  = trial - {1'b0, div_i.den};
    qbit  = ~diff[64];
    div_nxt.rem = qbit ? diff[63:0] : trial[63:0];
    div_nxt.num = {div_i.num[62:0], qbit};
    div_nxt.den = div_i.den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_o  = div_r;
  assign side_o = side_r;

endmodule

### rtl/btpc_back.sv
module btpc_back import btpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic [63:0] quo,
  input  side_t       side_i,
  input  cal_t        cal,
  output res_t        res_o
);

  side_t side_r [1:4];
  logic [63:0] q1_r, ps1_r, q2_r, ps2_r, a9_r, w2_r, w2_3_r, q3_r;
  logic [63:0] ll_r, s_r;
  logic [31:0] c1_r, c2_r;
  logic [63:0] q_nxt, ps_nxt, w2_nxt, ll_nxt, prod, w1, s_nxt, press;
  logic [31:0] c1_nxt, c2_nxt;
  logic signed [79:0] a9_full, w2_full;
  res_t res_r;

  always_comb begin
    q_nxt   = side_i.qneg ? (64'd0 - quo) : quo;
    ps_nxt  = $signed(q_nxt) >>> 13;
    a9_full = $signed(cal.p9) * $signed(ps1_r);
    w2_full = $signed(cal.p8) * $signed(q1_r);
    w2_nxt  = $signed(w2_full[63:0]) >>> 19;
    // low 64 bits of a9 * ps from 32-bit partial products
    ll_nxt  = {32'b0, a9_r[31:0]} * {32'b0, ps2_r[31:0]};
    c1_nxt  = a9_r[31:0] * ps2_r[63:32];
    c2_nxt  = a9_r[63:32] * ps2_r[31:0];
    prod    = ll_r + {c1_r + c2_r, 32'b0};
    w1      = $signed(prod) >>> 25;
    s_nxt   = q3_r + w1 + w2_3_r;
    press   = ($signed(s_r) >>> 8) + ({{48{cal.p7[15]}}, cal.p7} << 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 4; i++) side_r[i] <= '0;
      res_r.v <= 1'b0;
    end else if (adv) begin
      side_r[1] <= side_i;
      for (int i = 2; i <= 4; i++) side_r[i] <= side_r[i-1];
      res_r.v       <= side_r[4].v;
      res_r.invalid <= side_r[4].invalid;
      res_r.press   <= side_r[4].invalid ? 32'd0 : press[31:0];
      res_r.tfine   <= side_r[4].tfine;
      res_r.tcenti  <= side_r[4].tcenti;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_r   <= q_nxt;
      ps1_r  <= ps_nxt;
      a9_r   <= a9_full[63:0];
      w2_r   <= w2_nxt;
      q2_r   <= q1_r;
      ps2_r  <= ps1_r;
      ll_r   <= ll_nxt;
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      q3_r   <= q2_r;
      w2_3_r <= w2_r;
      s_r    <= s_nxt;
    end
  end

  assign res_o = res_r;

endmodule

### tb/baro_temp_press_compensation_checker.sv
`timescale 1ns / 100ps

module baro_temp_press_compensation_checker import btpc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [39:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  cfg_reg_t     cfg_index,
  input  logic [63:0]  cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic        invalid;
    logic [31:0] press;
    logic [31:0] tfine;
    logic [31:0] tcenti;
  } reading_t;

  localparam logic signed [63:0] MOST_NEG = 64'sh8000_0000_0000_0000;

  logic [47:0] temp_cal;
  logic [63:0] press_lo, press_hi;
  logic [15:0] press_p9;
  reading_t    expected_readings[$];

  function automatic logic signed [63:0] sword(input logic [15:0] w);
    logic signed [63:0] r;
    r = $signed(w);
    return r;
  endfunction

  function automatic reading_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
    logic signed [31:0] t1, t2, t3, a, b, sq, tv1, tv2, tfine;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, prod, aux, pr, num, q, ps, w1, w2;
    reading_t r;
    t1 = {16'd0, temp_cal[15:0]};
    t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
    a = {15'd0, raw_t[19:3]} - (t1 <<< 1);
    tv1 = (a * t2) >>> 11;
    b = {16'd0, raw_t[19:4]} - t1;
    sq = (b * b) >>> 12;
    tv2 = (sq * t3) >>> 14;
    tfine = tv1 + tv2;
    r.tfine = tfine;
    r.tcenti = (tfine * 32'sd5 + 32'sd128) >>> 8;

    p1 = {48'd0, press_lo[15:0]};
    p2 = sword(press_lo[31:16]);
    p3 = sword(press_lo[47:32]);
    p4 = sword(press_lo[63:48]);
    p5 = sword(press_hi[15:0]);
    p6 = sword(press_hi[31:16]);
    p7 = sword(press_hi[47:32]);
    p8 = sword(press_hi[63:48]);
    p9 = sword(press_p9);

    v1 = tfine;
    v1 = v1 - $signed({32'd0, TEMP_REF_OFFSET});
    v2 = v1 * v1 * p6;
    prod = v1 * p5;
    v2 = v2 + (prod <<< P5_SHIFT);
    v2 = v2 + (p4 <<< P4_SHIFT);
    prod = v1 * v1 * p3;
    aux = v1 * p2;
    v1 = (prod >>> 8) + (aux <<< 12);
    prod = ($signed(P1_BIAS) + v1) * p1;
    v1 = prod >>> 33;

    r.invalid = 1'b0;
    r.press = '0;
    if (v1 == 0) begin
      r.invalid = 1'b1;
    end else begin
      pr = $signed(PRESS_FULL_SCALE) - $signed({44'd0, raw_p});
      num = ((pr <<< 31) - v2) * $signed(PRESS_SCALE);
      // the one overflowing quotient wraps
      if (num == MOST_NEG && v1 == -64'sd1) q = MOST_NEG;
      else q = num / v1;
      ps = q >>> 13;
      w1 = (p9 * ps * ps) >>> 25;
      w2 = (p8 * q) >>> 19;
      pr = ((q + w1 + w2) >>> 8) + (p7 <<< 4);
      r.press = pr[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t e, got;
    if (!rst_n) begin
      temp_cal <= '0;
      press_lo <= '0;
      press_hi <= '0;
      press_p9 <= '0;
      expected_readings.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TEMP_CAL: temp_cal <= cfg_data[47:0];
          REG_PRESS_LO: press_lo <= cfg_data;
          REG_PRESS_HI: press_hi <= cfg_data;
          REG_PRESS_P9: press_p9 <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_readings.push_back(compensate(in_tdata[19:0], in_tdata[39:20]));
      if (out_tvalid && out_tready) begin
        got = out_tdata[96:0];
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected item %h", $time, got);
          errors <= errors + 1;
        end else begin
          e = expected_readings.pop_front();
          if (got.tcenti !== e.tcenti || got.tfine !== e.tfine ||
              got.press !== e.press || got.invalid !== e.invalid) begin
            $display("%0t: mismatch tcenti exp %h got %h, tfine exp %h got %h",
                     $time, e.tcenti, got.tcenti, e.tfine, got.tfine);
            $display("%0t: mismatch press exp %h got %h, invalid exp %b got %b",
                     $time, e.press, got.press, e.invalid, got.invalid);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_readings.size();
    end
  end

endmodule

### tb/baro_temp_press_compensation_tb.sv
`timescale 1ns / 100ps

module baro_temp_press_compensation_tb;
  import btpc_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  cfg_reg_t     cfg_index = REG_TEMP_CAL;
  logic [63:0]  cfg_data = '0;
  int           errors, pending;
  bit           no_idle = 1'b0;

  always #6 clk = ~clk;

  baro_temp_press_compensation dut (.*);

  baro_temp_press_compensation_checker checker_i (.*);

  task automatic cfg_write(input cfg_reg_t idx, input logic [63:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_cal(input logic [47:0] t, input logic [63:0] lo, input logic [63:0] hi,
                         input logic [15:0] p9);
    cfg_write(REG_TEMP_CAL, {$urandom, 16'd0, t[47:32]} << 32 | t);
    cfg_write(REG_PRESS_LO, lo);
    cfg_write(REG_PRESS_HI, hi);
    cfg_write(REG_PRESS_P9, {$urandom, $urandom} << 16 | p9);
  endtask

  // hold valid high across back-to-back items
  task automatic send(input logic [19:0] raw_t, input logic [19:0] raw_p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {raw_p, raw_t};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0 || out_tvalid) @(negedge clk);
    repeat (90) @(negedge clk);
  endtask

  function automatic logic [19:0] raw_sample(input logic near);
    if (near) return 20'(32'd400000 + $urandom_range(0, 250000));
    return 20'($urandom);
  endfunction

  always begin
    int stall;
    stall = no_idle ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    out_tready = 1'b0;
    repeat (stall) @(negedge clk);
    out_tready = 1'b1;
    do @(posedge clk); while (!out_tvalid);
  end

  localparam logic [47:0] TYP_T = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_LO = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_HI = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // reset calibration: zero divisor on every item
    send(20'h00000, 20'h00000);
    send(20'hFFFFF, 20'hFFFFF);
    drain();

    set_cal(TYP_T, TYP_LO, TYP_HI, 16'd6000);
    send(20'd519888, 20'd415148);
    send(20'h00000, 20'h00000);
    send(20'hFFFFF, 20'hFFFFF);
    send(20'h00000, 20'hFFFFF);
    send(20'hFFFFF, 20'h00000);
    send(20'hAAAAA, 20'h55555);
    send(20'h55555, 20'hAAAAA);
    drain();

    set_cal('1, '1, '1, 16'hFFFF);
    send(20'h00000, 20'h00000);
    send(20'hFFFFF, 20'hFFFFF);
    send(20'h80000, 20'h7FFFF);
    drain();

    set_cal({16'h8000, 16'h8000, 16'hFFFF}, {{3{16'h8000}}, 16'hFFFF},
            {4{16'h8000}}, 16'h8000);
    send(20'h00000, 20'hFFFFF);
    send(20'hFFFFF, 20'h00000);
    send(20'h12345, 20'h6789A);
    drain();

    set_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {{3{16'h7FFF}}, 16'h0001},
            {4{16'h7FFF}}, 16'h7FFF);
    send(20'h00000, 20'h00000);
    send(20'hFFFFF, 20'hFFFFF);
    send(20'h40000, 20'hC0000);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph % 3)
        0: set_cal(TYP_T ^ 48'($urandom_range(0, 255)), TYP_LO ^ 64'($urandom_range(0, 255)),
                   TYP_HI ^ 64'($urandom_range(0, 255)), 16'(5000 + $urandom_range(0, 2000)));
        1: set_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   16'($urandom));
        default: set_cal(TYP_T, TYP_LO, TYP_HI, 16'd6000);
      endcase
      no_idle = (ph == 2);
      for (int i = 0; i < 200; i++) begin
        logic near;
        near = ($urandom_range(0, 3) != 0);
        send(raw_sample(near), raw_sample(near));
      end
      // sender holds off until every expected item is back
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/btpc_pkg.sv
rtl/btpc_front.sv
rtl/btpc_div_cell.sv
rtl/btpc_back.sv
rtl/baro_temp_press_compensation.sv
tb/baro_temp_press_compensation_checker.sv
tb/baro_temp_press_compensation_tb.sv
